/* hw/rtl/bldcrc_pkg.sv */
// Shared types, constants and functions for the binary log deframer.
// Used by bldcrc_core and binary_log_deframer_crc32; depends on nothing else.
`timescale 1ns / 1ps

package bldcrc_pkg;

	localparam logic [7:0]  SYNC_A     = 8'hAA;
	localparam logic [7:0]  SYNC_B     = 8'h44;
	localparam logic [7:0]  SYNC_C     = 8'h12;
	localparam logic [16:0] HEADER_LEN = 17'd28;
	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [16:0] MAX_LEN_RESET = 17'd16380;

	// Header byte offsets.
	localparam logic [16:0] OFF_SYNC_END = 17'd2;
	localparam logic [16:0] OFF_FIRST    = 17'd3;
	localparam logic [16:0] OFF_ID_LO    = 17'd4;
	localparam logic [16:0] OFF_ID_HI    = 17'd5;
	localparam logic [16:0] OFF_FORMAT   = 17'd6;
	localparam logic [16:0] OFF_LEN_LO   = 17'd8;
	localparam logic [16:0] OFF_LEN_HI   = 17'd9;
	localparam logic [16:0] OFF_BODY     = 17'd10;

	localparam logic [15:0] ID_A = 16'd140;
	localparam logic [15:0] ID_B = 16'd41;
	localparam logic [15:0] ID_C = 16'd71;
	localparam logic [15:0] ID_D = 16'd723;

	localparam logic [1:0] FORMAT_BINARY = 2'b00;

	typedef enum logic [2:0] {
		ST_NONE          = 3'd0,
		ST_LEN_ERROR     = 3'd1,
		ST_CRC_ERROR     = 3'd2,
		ST_ASCII_IGNORED = 3'd3,
		ST_GOOD_KNOWN    = 3'd4,
		ST_GOOD_UNKNOWN  = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [16:0] byte_offset;
		logic        frame_end;
		status_t     status;
		logic [15:0] message_id;
		logic [16:0] message_length;
	} result_t;

	// Reflected CRC-32 update by one byte, eight bit steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	localparam logic [31:0] CRC_AFTER_SYNC =
		crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

	function automatic logic known_id(input logic [15:0] id);
		return (id == ID_A) || (id == ID_B) || (id == ID_C) || (id == ID_D);
	endfunction

endpackage

/* hw/rtl/bldcrc_core.sv */
// Frame state and per-byte decode: sync hunt, header capture, CRC and status.
// Depends on bldcrc_pkg.
`timescale 1ns / 1ps

module bldcrc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  logic [16:0]         cfg_data,
	input  logic                step,
	input  logic [7:0]          data_byte,
	output logic                res_valid,
	output bldcrc_pkg::result_t res
);

	logic [16:0] max_len_q;
	logic [15:0] hist_q, hist_n;
	logic [16:0] count_q, count_n;
	logic [16:0] flen_q, flen_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] rx_q, rx_n;
	logic [15:0] id_q, id_n;
	logic [1:0]  fmt_q, fmt_n;
	logic [16:0] flen_hdr;

	always_comb begin
		hist_n  = hist_q;
		count_n = count_q;
		flen_n  = flen_q;
		crc_n   = crc_q;
		rx_n    = rx_q;
		id_n    = id_q;
		fmt_n   = fmt_q;
		res_valid = 1'b0;
		res.byte_value     = data_byte;
		res.byte_offset    = count_q;
		res.frame_end      = 1'b0;
		res.status         = bldcrc_pkg::ST_NONE;
		res.message_id     = 16'd0;
		res.message_length = 17'd0;
		flen_hdr = {1'b0, data_byte, flen_q[7:0]} + bldcrc_pkg::HEADER_LEN;

		if (count_q == 17'd0) begin
			if (hist_q == {bldcrc_pkg::SYNC_A, bldcrc_pkg::SYNC_B} &&
			    data_byte == bldcrc_pkg::SYNC_C) begin
				hist_n  = 16'd0;
				count_n = bldcrc_pkg::OFF_FIRST;
				crc_n   = bldcrc_pkg::CRC_AFTER_SYNC;
				rx_n    = 32'd0;
				flen_n  = 17'd0;
				id_n    = 16'd0;
				fmt_n   = 2'd0;
				res_valid = 1'b1;
				res.byte_offset = bldcrc_pkg::OFF_SYNC_END;
			end else begin
				hist_n = {hist_q[7:0], data_byte};
			end
		end else begin
			res_valid = 1'b1;
			count_n = count_q + 17'd1;

			if (count_q == bldcrc_pkg::OFF_ID_LO) begin
				id_n = {id_q[15:8], data_byte};
			end else if (count_q == bldcrc_pkg::OFF_ID_HI) begin
				id_n = {data_byte, id_q[7:0]};
			end else if (count_q == bldcrc_pkg::OFF_FORMAT) begin
				fmt_n = data_byte[5:4];
			end else if (count_q == bldcrc_pkg::OFF_LEN_LO) begin
				flen_n = {9'd0, data_byte};
			end

			// Header and body feed the CRC; the four bytes after them are the received CRC.
			if (count_q < bldcrc_pkg::OFF_BODY || count_q < flen_q) begin
				crc_n = bldcrc_pkg::crc_byte(crc_q, data_byte);
			end else begin
				rx_n = {data_byte, rx_q[31:8]};
			end

			if (count_q == bldcrc_pkg::OFF_LEN_HI) begin
				flen_n = flen_hdr;
				if (flen_hdr > max_len_q) begin
					count_n = 17'd0;
					res.frame_end      = 1'b1;
					res.status         = bldcrc_pkg::ST_LEN_ERROR;
					res.message_id     = id_q;
					res.message_length = flen_hdr;
				end
			end else if (count_q >= bldcrc_pkg::OFF_BODY &&
			             ({1'b0, count_q} + 18'd1) >= ({1'b0, flen_q} + 18'd4)) begin
				count_n = 17'd0;
				res.frame_end      = 1'b1;
				res.message_id     = id_q;
				res.message_length = flen_q;
				if (crc_n != rx_n) begin
					res.status = bldcrc_pkg::ST_CRC_ERROR;
				end else if (fmt_q != bldcrc_pkg::FORMAT_BINARY) begin
					res.status = bldcrc_pkg::ST_ASCII_IGNORED;
				end else if (bldcrc_pkg::known_id(id_q)) begin
					res.status = bldcrc_pkg::ST_GOOD_KNOWN;
				end else begin
					res.status = bldcrc_pkg::ST_GOOD_UNKNOWN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= bldcrc_pkg::MAX_LEN_RESET;
		end else if (cfg_wr) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= 16'd0;
			count_q <= 17'd0;
			flen_q  <= 17'd0;
			crc_q   <= 32'd0;
			rx_q    <= 32'd0;
			id_q    <= 16'd0;
			fmt_q   <= 2'd0;
		end else if (step) begin
			hist_q  <= hist_n;
			count_q <= count_n;
			flen_q  <= flen_n;
			crc_q   <= crc_n;
			rx_q    <= rx_n;
			id_q    <= id_n;
			fmt_q   <= fmt_n;
		end
	end

endmodule

/* hw/rtl/binary_log_deframer_crc32.sv */
// Binary log deframer with CRC-32 check: stream ports, input and result registers.
// Depends on bldcrc_pkg and bldcrc_core.
// An accepted byte is first held in the input register; its result is then written to the
// result register, from which the output stream presents it.
// Throughput: one byte per cycle unless m_tready stalls the result register; the byte-wide
// CRC update and the offset counter are combinational between the input and result registers.
// Reset clears all frame state, puts the block in sync hunt and loads the length limit 16380.
`timescale 1ns / 1ps

module binary_log_deframer_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] byte_value, [24:8] byte_offset,
	                               // [40:25] message_id, [57:41] message_length, rest zero
	output logic [3:0]  m_tuser,   // [0] byte_valid, [3:1] status
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data   // max_frame_len
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                out_valid_q;
	bldcrc_pkg::result_t out_q;
	logic                advance;
	logic                step;
	logic                res_valid;
	bldcrc_pkg::result_t res;

	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	bldcrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.step      (step),
		.data_byte (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.message_length, out_q.message_id,
	                   out_q.byte_offset, out_q.byte_value};
	assign m_tuser  = {out_q.status, 1'b1};
	assign m_tlast  = out_q.frame_end;

	// A length error is only ever raised on the high length byte.
	a_len_err_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status == bldcrc_pkg::ST_LEN_ERROR |->
			out_q.byte_offset == bldcrc_pkg::OFF_LEN_HI && out_q.frame_end)
		else $error("length error away from the length field");

	// Bytes inside a frame carry no id or length.
	a_mid_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |->
			out_q.message_id == 16'd0 && out_q.message_length == 17'd0 &&
			out_q.status == bldcrc_pkg::ST_NONE)
		else $error("header fields on a byte that does not end a frame");

	// With the result register empty the input side must not stall.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with an empty result register");

	// A frame end other than a length error closes a frame of at least the header length plus CRC.
	a_end_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && out_q.status != bldcrc_pkg::ST_LEN_ERROR |->
			out_q.byte_offset >= (bldcrc_pkg::HEADER_LEN + 17'd3))
		else $error("frame ended before header and CRC were complete");

endmodule

/* dv/tb_binary_log_deframer_crc32.sv */
// Self-checking testbench for binary_log_deframer_crc32: drives framed byte streams,
// predicts every forwarded byte and frame verdict, and checks the result stream.
// Depends on bldcrc_pkg and the binary_log_deframer_crc32 RTL.
`timescale 1ns / 1ps

module tb_binary_log_deframer_crc32;

	localparam int STALL_LIMIT = 2000;
	// Margin left after the last result before a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES_PER_PHASE = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;     // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;            // [7:0] byte_value, [24:8] byte_offset,
	                                 // [40:25] message_id, [57:41] message_length
	logic [3:0]  m_tuser;            // [0] byte_valid, [3:1] status
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = 17'd0;  // max_frame_len

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int frame_bytes_out = 0;

	// Deframer prediction state.
	logic [16:0] max_len = bldcrc_pkg::MAX_LEN_RESET;
	logic [15:0] hunt_hist = '0;
	logic [16:0] frame_pos = '0;
	logic [16:0] frame_len = '0;
	logic [31:0] crc_calc = '0;
	logic [31:0] crc_rcvd = '0;
	logic [15:0] hdr_id = '0;
	logic [1:0]  fmt_bits = '0;

	bldcrc_pkg::result_t pending_results[$];
	bldcrc_pkg::result_t want;

	binary_log_deframer_crc32 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] c;
		c = acc;
		for (int k = 0; k < 8; k++) begin
			c = (c[0] ^ d[k]) ? ((c >> 1) ^ bldcrc_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Advance the deframer state by one accepted byte and queue the result it causes.
	task automatic predict_deframe(input logic [7:0] b);
		logic [16:0] off;
		bldcrc_pkg::result_t r;
		r.byte_value = b;
		r.byte_offset = '0;
		r.frame_end = 1'b0;
		r.status = bldcrc_pkg::ST_NONE;
		r.message_id = '0;
		r.message_length = '0;
		if (frame_pos == '0) begin
			if (hunt_hist == {bldcrc_pkg::SYNC_A, bldcrc_pkg::SYNC_B} &&
			    b == bldcrc_pkg::SYNC_C) begin
				hunt_hist = '0;
				frame_pos = bldcrc_pkg::OFF_FIRST;
				crc_calc = crc32_update(crc32_update(crc32_update(32'd0,
					bldcrc_pkg::SYNC_A), bldcrc_pkg::SYNC_B), bldcrc_pkg::SYNC_C);
				crc_rcvd = '0;
				frame_len = '0;
				hdr_id = '0;
				fmt_bits = '0;
				r.byte_offset = bldcrc_pkg::OFF_SYNC_END;
				pending_results.push_back(r);
				frame_bytes_out++;
			end else begin
				hunt_hist = {hunt_hist[7:0], b};
			end
		end else begin
			off = frame_pos;
			frame_pos = frame_pos + 17'd1;
			r.byte_offset = off;
			case (off)
				bldcrc_pkg::OFF_ID_LO:  hdr_id[7:0] = b;
				bldcrc_pkg::OFF_ID_HI:  hdr_id[15:8] = b;
				bldcrc_pkg::OFF_FORMAT: fmt_bits = b[5:4];
				bldcrc_pkg::OFF_LEN_LO: frame_len = {9'd0, b};
				default: ;
			endcase
			if (off < bldcrc_pkg::OFF_BODY || off < frame_len) begin
				crc_calc = crc32_update(crc_calc, b);
			end else begin
				crc_rcvd = {b, crc_rcvd[31:8]};
			end
			if (off == bldcrc_pkg::OFF_LEN_HI) begin
				frame_len = {1'b0, b, frame_len[7:0]} + bldcrc_pkg::HEADER_LEN;
				if (frame_len > max_len) begin
					frame_pos = '0;
					r.frame_end = 1'b1;
					r.status = bldcrc_pkg::ST_LEN_ERROR;
					r.message_id = hdr_id;
					r.message_length = frame_len;
				end
			end else if (off >= bldcrc_pkg::OFF_BODY &&
			             ({1'b0, off} + 18'd1) >= ({1'b0, frame_len} + 18'd4)) begin
				frame_pos = '0;
				r.frame_end = 1'b1;
				r.message_id = hdr_id;
				r.message_length = frame_len;
				// A bad checksum wins over an ascii format.
				if (crc_calc != crc_rcvd) begin
					r.status = bldcrc_pkg::ST_CRC_ERROR;
				end else if (fmt_bits != bldcrc_pkg::FORMAT_BINARY) begin
					r.status = bldcrc_pkg::ST_ASCII_IGNORED;
				end else if (hdr_id == bldcrc_pkg::ID_A || hdr_id == bldcrc_pkg::ID_B
						|| hdr_id == bldcrc_pkg::ID_C || hdr_id == bldcrc_pkg::ID_D) begin
					r.status = bldcrc_pkg::ST_GOOD_KNOWN;
				end else begin
					r.status = bldcrc_pkg::ST_GOOD_UNKNOWN;
				end
			end
			pending_results.push_back(r);
			frame_bytes_out++;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_deframe(b);
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++) begin
			send_byte(8'($urandom));
		end
	endtask

	// Sends one frame with random filler. A frame whose length is over the current limit
	// stops after the length word, since the deframer goes back to hunting there.
	task automatic send_frame(input logic [15:0] id, input logic [7:0] fmt_byte,
			input logic [15:0] word, input logic [31:0] crc_flip);
		int total;
		int stop;
		logic [31:0] crc;
		logic [7:0] b;
		total = int'(word) + int'(bldcrc_pkg::HEADER_LEN);
		stop = (total > int'(max_len)) ? int'(bldcrc_pkg::OFF_LEN_HI) + 1 : total;
		crc = '0;
		for (int off = 0; off < stop; off++) begin
			case (off)
				0:                               b = bldcrc_pkg::SYNC_A;
				1:                               b = bldcrc_pkg::SYNC_B;
				int'(bldcrc_pkg::OFF_SYNC_END):  b = bldcrc_pkg::SYNC_C;
				int'(bldcrc_pkg::OFF_ID_LO):     b = id[7:0];
				int'(bldcrc_pkg::OFF_ID_HI):     b = id[15:8];
				int'(bldcrc_pkg::OFF_FORMAT):    b = fmt_byte;
				int'(bldcrc_pkg::OFF_LEN_LO):    b = word[7:0];
				int'(bldcrc_pkg::OFF_LEN_HI):    b = word[15:8];
				default:                         b = 8'($urandom);
			endcase
			crc = crc32_update(crc, b);
			send_byte(b);
		end
		if (stop == total) begin
			crc = crc ^ crc_flip;
			for (int k = 0; k < 4; k++) begin
				send_byte(crc[8 * k +: 8]);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [16:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len = v;
	endtask

	task automatic random_frame();
		int pick;
		int cap;
		int lo;
		logic [15:0] id;
		logic [7:0] fmt;
		logic [15:0] word;
		logic [31:0] flip;
		logic [7:0] tail;
		pick = $urandom_range(99);
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(3))
				0:       id = bldcrc_pkg::ID_A;
				1:       id = bldcrc_pkg::ID_B;
				2:       id = bldcrc_pkg::ID_C;
				default: id = bldcrc_pkg::ID_D;
			endcase
		end else begin
			id = 16'($urandom);
		end
		fmt = 8'($urandom);
		fmt[5:4] = bldcrc_pkg::FORMAT_BINARY;
		cap = int'(max_len) - int'(bldcrc_pkg::HEADER_LEN);
		if (cap < 0) cap = 0;
		if (cap > (($urandom_range(9) == 0) ? 400 : 24)) cap = ($urandom_range(1) == 0) ? 400 : 24;
		if (cap > int'(max_len) - int'(bldcrc_pkg::HEADER_LEN)) cap = 0;
		word = 16'($urandom_range(cap, 0));
		flip = '0;
		if (pick < 12) begin
			flip = 32'd1 << $urandom_range(31);
		end else if (pick < 22) begin
			fmt[5:4] = 2'($urandom_range(3, 1));
		end else if (pick < 30) begin
			lo = (max_len < bldcrc_pkg::HEADER_LEN) ? 0 :
				int'(max_len) - int'(bldcrc_pkg::HEADER_LEN) + 1;
			if (lo <= 65535) word = 16'($urandom_range(65535, lo));
		end
		if (pick >= 30 && pick < 36) begin
			// Sync pattern broken in its last byte.
			tail = 8'($urandom);
			if (tail == bldcrc_pkg::SYNC_C) tail = ~tail;
			send_byte(bldcrc_pkg::SYNC_A);
			send_byte(bldcrc_pkg::SYNC_B);
			send_byte(tail);
		end else if (pick >= 36 && pick < 40) begin
			send_noise($urandom_range(6, 1));
		end else begin
			send_frame(id, fmt, word, flip);
		end
		if ($urandom_range(3) == 0) send_noise($urandom_range(3, 1));
	endtask

	task automatic test_sync_hunt();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(bldcrc_pkg::SYNC_C);
		send_byte(bldcrc_pkg::SYNC_A);
		send_byte(bldcrc_pkg::SYNC_B);
		send_byte(8'h13);
		send_byte(bldcrc_pkg::SYNC_B);
		send_byte(bldcrc_pkg::SYNC_C);
		// An extra leading sync byte must not hide the pattern.
		send_byte(bldcrc_pkg::SYNC_A);
		send_frame(bldcrc_pkg::ID_A, 8'h00, 16'd0, 32'd0);
		// Length word AA 44 is over the reset limit; the frame ends there and the
		// next byte must not complete a sync with the frame's last two bytes.
		send_frame(16'h1234, 8'h00, {bldcrc_pkg::SYNC_B, bldcrc_pkg::SYNC_A}, 32'd0);
		send_byte(bldcrc_pkg::SYNC_C);
		drain_results();
	endtask

	task automatic test_status_codes();
		src_idle_pct = 11;
		sink_stall_pct = 11;
		send_frame(bldcrc_pkg::ID_B, 8'h00, 16'd0, 32'd0);
		send_frame(bldcrc_pkg::ID_C, 8'h00, 16'd5, 32'd0);
		send_frame(bldcrc_pkg::ID_D, 8'h00, 16'd1, 32'd0);
		send_frame(16'h0000, 8'h00, 16'd0, 32'd0);
		send_frame(16'hFFFF, 8'hCF, 16'd3, 32'd0);
		send_frame(bldcrc_pkg::ID_A, 8'h10, 16'd2, 32'd0);
		send_frame(bldcrc_pkg::ID_A, 8'h20, 16'd0, 32'd0);
		send_frame(bldcrc_pkg::ID_A, 8'hFF, 16'd4, 32'd0);
		send_frame(bldcrc_pkg::ID_A, 8'h00, 16'd0, 32'h8000_0000);
		send_frame(16'h7F3C, 8'h00, 16'd6, 32'h0000_0001);
		send_frame(bldcrc_pkg::ID_B, 8'h30, 16'd1, 32'h0001_0000);
		drain_results();
	endtask

	task automatic test_length_limit();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_max_len(17'd0);
		send_frame(bldcrc_pkg::ID_A, 8'h00, 16'd0, 32'd0);
		write_max_len(17'd27);
		send_frame(bldcrc_pkg::ID_B, 8'h00, 16'd0, 32'd0);
		write_max_len(17'd28);
		send_frame(bldcrc_pkg::ID_C, 8'h00, 16'd0, 32'd0);
		send_frame(bldcrc_pkg::ID_C, 8'h00, 16'd1, 32'd0);
		write_max_len(17'd40);
		send_frame(bldcrc_pkg::ID_D, 8'h00, 16'd12, 32'd0);
		send_frame(bldcrc_pkg::ID_D, 8'h00, 16'd13, 32'd0);
		// Longest length the header can describe, one above the limit.
		write_max_len(17'd65562);
		send_frame(16'hABCD, 8'h00, 16'hFFFF, 32'd0);
		write_max_len(17'd65563);
		send_frame(16'hABCD, 8'h00, 16'd3, 32'd0);
		write_max_len(17'h1FFFF);
		send_frame(16'h0102, 8'h00, 16'd7, 32'd0);
		drain_results();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input logic [16:0] limit);
		int start;
		bit paused;
		write_max_len(limit);
		src_idle_pct = idle;
		sink_stall_pct = stall;
		start = frame_bytes_out;
		paused = 1'b0;
		while (frame_bytes_out - start < RANDOM_BYTES_PER_PHASE) begin
			// Hold the sender once mid-phase until the result stream is empty.
			if (!paused && frame_bytes_out - start > RANDOM_BYTES_PER_PHASE / 2) begin
				drain_results();
				paused = 1'b1;
			end
			random_frame();
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result at byte_offset %0d", m_tdata[24:8]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[0] !== 1'b1) begin
					$error("byte_valid: expected 1, got %b", m_tuser[0]);
					fail_count++;
				end
				if (m_tdata[7:0] !== want.byte_value) begin
					$error("byte_value: expected %0h, got %0h", want.byte_value, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[24:8] !== want.byte_offset) begin
					$error("byte_offset: expected %0d, got %0d", want.byte_offset, m_tdata[24:8]);
					fail_count++;
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_end: expected %b, got %b", want.frame_end, m_tlast);
					fail_count++;
				end
				if (m_tuser[3:1] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[3:1]);
					fail_count++;
				end
				if (m_tdata[40:25] !== want.message_id) begin
					$error("message_id: expected %0d, got %0d", want.message_id, m_tdata[40:25]);
					fail_count++;
				end
				if (m_tdata[57:41] !== want.message_length) begin
					$error("message_length: expected %0d, got %0d", want.message_length,
						m_tdata[57:41]);
					fail_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_hunt();
		test_status_codes();
		test_length_limit();
		test_random_traffic(0, 0, bldcrc_pkg::MAX_LEN_RESET);
		test_random_traffic(70, 0, 17'($urandom_range(200, 28)));
		test_random_traffic(0, 70, 17'h1FFFF);
		test_random_traffic(11, 11, 17'd65563);
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
